// File: rtl/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg: shared types and constants for the radix text parser
// Character codes, status codes and the digit and prefix decoders.
// ----------------------------------------------------------------------------
package rtt_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int RADIX_W         = 6;
    localparam int VALUE_W         = 64;
    localparam int STATUS_W        = 2;
    localparam int CH_W            = 8;

    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

    // Status codes of a result.
    localparam logic [STATUS_W-1:0] ST_COMPLETE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STOPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    // Character codes.
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LOW_Z  = 8'h7A;
    localparam logic [CH_W-1:0] CH_LOW_B  = 8'h62;
    localparam logic [CH_W-1:0] CH_LOW_D  = 8'h64;
    localparam logic [CH_W-1:0] CH_LOW_O  = 8'h6F;
    localparam logic [CH_W-1:0] CH_LOW_X  = 8'h78;
    localparam logic [CH_W-1:0] CASE_BIT  = 8'h20;
    localparam logic [CH_W-1:0] LETTER_OFS = 8'h57;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            has_char;
        logic            last;
    } item_t;

    typedef struct packed {
        logic               ok;
        logic [RADIX_W-1:0] val;
    } digit_t;

    // Digit value of a character; ok is low for anything that is no digit.
    function automatic digit_t decode_digit(input logic [CH_W-1:0] c);
        digit_t          d;
        logic [CH_W-1:0] low;
        logic [CH_W-1:0] diff;
        d    = '0;
        low  = c | CASE_BIT;
        diff = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            diff  = c - CH_ZERO;
            d.ok  = 1'b1;
            d.val = diff[RADIX_W-1:0];
        end else if (low >= CH_LOW_A && low <= CH_LOW_Z) begin
            diff  = low - LETTER_OFS;
            d.ok  = 1'b1;
            d.val = diff[RADIX_W-1:0];
        end
        return d;
    endfunction

    // Radix chosen by the character after a leading zero; zero if none.
    function automatic logic [RADIX_W-1:0] prefix_radix(input logic [CH_W-1:0] c);
        logic [RADIX_W-1:0] r;
        case (c)
            CH_LOW_B: r = 6'd2;
            CH_LOW_O: r = 6'd8;
            CH_LOW_D: r = 6'd10;
            CH_LOW_X: r = 6'd16;
            default:  r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/rtt_in_reg.sv
// ----------------------------------------------------------------------------
// rtt_in_reg: input register stage
// Captures one character word and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module rtt_in_reg
    import rtt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    output logic  q_valid,
    input  logic  q_take,
    output item_t q_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready = !valid_reg || q_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_ready)
        begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            item_reg <= s_item;
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

// File: rtl/rtt_core.sv
// ----------------------------------------------------------------------------
// rtt_core: parser state and result register
// One multiply by the radix and one add per character, then the result word.
// ----------------------------------------------------------------------------
module rtt_core
    import rtt_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [RADIX_W-1:0]     cfg_data,
    input  logic                   q_valid,
    output logic                   q_take,
    input  item_t                  q_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [VALUE_W-1:0]     m_value,
    output logic [STATUS_W-1:0]    m_status,
    output logic [LENGTH_BITS-1:0] m_length
);

    logic [RADIX_W-1:0]     mode_reg;
    logic [VALUE_W-1:0]     acc_reg,    acc_next;
    logic [LENGTH_BITS-1:0] pos_reg,    pos_next;
    logic [STATUS_W-1:0]    stop_reg,   stop_next;
    logic [RADIX_W-1:0]     radix_reg,  radix_next;
    logic                   lzs_reg,    lzs_next;
    logic                   mval_reg,   mval_next;
    logic [VALUE_W-1:0]     oval_reg,   oval_next;
    logic [STATUS_W-1:0]    ost_reg,    ost_next;
    logic [LENGTH_BITS-1:0] olen_reg,   olen_next;

    logic                   fire;
    logic                   feed_en;
    logic [RADIX_W-1:0]     feed_r;
    logic [LENGTH_BITS-1:0] pos_in;
    logic [RADIX_W-1:0]     pre_r;
    digit_t                 dig;
    logic [VALUE_W+RADIX_W-1:0] prod;
    logic [VALUE_W:0]       sum;

    assign fire   = q_valid && (!mval_reg || m_ready);
    assign q_take = fire;

    assign dig   = decode_digit(q_item.ch);
    assign pre_r = prefix_radix(q_item.ch);
    assign prod  = (VALUE_W+RADIX_W)'(acc_reg) * (VALUE_W+RADIX_W)'(feed_r);
    assign sum   = {1'b0, prod[VALUE_W-1:0]} + (VALUE_W+1)'(dig.val);

    always_comb
    begin
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        stop_next  = stop_reg;
        radix_next = radix_reg;
        lzs_next   = lzs_reg;
        feed_en    = 1'b0;
        feed_r     = radix_reg;
        pos_in     = pos_reg;
        mval_next  = mval_reg && !m_ready;
        oval_next  = oval_reg;
        ost_next   = ost_reg;
        olen_next  = olen_reg;

        if (fire)
        begin
            if (q_item.has_char)
            begin
                if (radix_reg != '0)
                begin
                    feed_en = 1'b1;
                end
                else if (lzs_reg)
                begin
                    lzs_next = 1'b0;
                    if (pre_r != '0)
                    begin
                        radix_next = pre_r;
                        pos_next   = LENGTH_BITS'(2);
                    end
                    else
                    begin
                        // The held-back zero is a digit of its own in radix ten.
                        radix_next = RADIX_DEC;
                        feed_r     = RADIX_DEC;
                        pos_in     = LENGTH_BITS'(1);
                        pos_next   = pos_in;
                        feed_en    = 1'b1;
                    end
                end
                else if (mode_reg == '0)
                begin
                    if (q_item.ch == CH_ZERO && !q_item.last)
                    begin
                        lzs_next = 1'b1;
                    end
                    else
                    begin
                        radix_next = RADIX_DEC;
                        feed_r     = RADIX_DEC;
                        feed_en    = 1'b1;
                    end
                end
                else
                begin
                    radix_next = mode_reg;
                    feed_r     = mode_reg;
                    feed_en    = 1'b1;
                end
            end

            if (feed_en && stop_reg == ST_COMPLETE)
            begin
                if (!dig.ok || dig.val >= feed_r)
                begin
                    stop_next = ST_STOPPED;
                end
                else if (prod[VALUE_W+RADIX_W-1:VALUE_W] != '0)
                begin
                    stop_next = ST_OVERFLOW;
                end
                else
                begin
                    acc_next = sum[VALUE_W-1:0];
                    if (sum[VALUE_W])
                    begin
                        stop_next = ST_OVERFLOW;
                    end
                    else if (!(&pos_in))
                    begin
                        pos_next = pos_in + LENGTH_BITS'(1);
                    end
                end
            end

            if (q_item.last)
            begin
                mval_next = 1'b1;
                if (radix_next == '0 && !lzs_next)
                begin
                    oval_next = '0;
                    ost_next  = ST_STOPPED;
                    olen_next = '0;
                end
                else if (lzs_next)
                begin
                    oval_next = '0;
                    ost_next  = ST_COMPLETE;
                    olen_next = LENGTH_BITS'(1);
                end
                else
                begin
                    oval_next = acc_next;
                    ost_next  = stop_next;
                    olen_next = pos_next;
                end
                acc_next   = '0;
                pos_next   = '0;
                stop_next  = ST_COMPLETE;
                radix_next = '0;
                lzs_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= '0;
            acc_reg   <= '0;
            pos_reg   <= '0;
            stop_reg  <= ST_COMPLETE;
            radix_reg <= '0;
            lzs_reg   <= 1'b0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mode_reg <= (cfg_data > RADIX_MAX) ? RADIX_MAX : cfg_data;
            end
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
            stop_reg  <= stop_next;
            radix_reg <= radix_next;
            lzs_reg   <= lzs_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oval_reg <= oval_next;
        ost_reg  <= ost_next;
        olen_reg <= olen_next;
    end

    assign m_valid  = mval_reg;
    assign m_value  = oval_reg;
    assign m_status = ost_reg;
    assign m_length = olen_reg;

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg <= RADIX_MAX)
        else $error("radix mode register above the largest radix");

    a_stop_needs_radix: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg != ST_COMPLETE |-> radix_reg != '0)
        else $error("parse stopped without a chosen radix");

    a_zero_pending: assert property (@(posedge clk) disable iff (!rst_n)
        lzs_reg |-> (radix_reg == '0 && pos_reg == '0 && acc_reg == '0))
        else $error("held-back zero with parse state already in use");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        fire && q_item.last |=> (acc_reg == '0 && pos_reg == '0 && radix_reg == '0
                                 && !lzs_reg && m_valid))
        else $error("state not cleared or result missing after end of string");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid |-> (m_status == ST_COMPLETE || m_status == ST_STOPPED
                     || m_status == ST_OVERFLOW))
        else $error("result carries an unknown status");

endmodule

// File: rtl/radix_text_to_uint64.sv
// The tlast word passes the input register and then the core's result register,
// provided the result register is free; a waiting result holds the input back.
// Throughput: one character word per cycle while no waiting result holds the input back;
// the multiply-by-radix and add that feed the accumulator are combinational.
// One result word per string, emitted on the word that carries tlast.
// Reset (rst_n low, asynchronous) clears the parse state, the radix mode and both stages.
// ----------------------------------------------------------------------------
// radix_text_to_uint64: streaming text to 64-bit unsigned integer parser
// Parses a character stream in a fixed or prefix-selected radix.
// ----------------------------------------------------------------------------
module radix_text_to_uint64
    import rtt_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int M_TDATA_W   = ((VALUE_W + STATUS_W + LENGTH_BITS + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [RADIX_W-1:0]   cfg_data,   // radix_mode
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CH_W-1:0]      s_tdata,    // ch
    input  logic                 s_tuser,    // has_char
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata     // result_value, status, used_length, zero pad
);

    item_t                  s_item;
    item_t                  q_item;
    logic                   q_valid;
    logic                   q_take;
    logic [VALUE_W-1:0]     value;
    logic [STATUS_W-1:0]    status;
    logic [LENGTH_BITS-1:0] used_length;

    assign cfg_ready = 1'b1;

    assign s_item.ch       = s_tdata;
    assign s_item.has_char = s_tuser;
    assign s_item.last     = s_tlast;

    rtt_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_item  (q_item)
    );

    rtt_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_item    (q_item),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_value   (value),
        .m_status  (status),
        .m_length  (used_length)
    );

    always_comb
    begin
        m_tdata = '0;
        m_tdata[VALUE_W-1:0] = value;
        m_tdata[VALUE_W +: STATUS_W] = status;
        m_tdata[VALUE_W+STATUS_W +: LENGTH_BITS] = used_length;
    end

endmodule

// File: sim/tb_radix_text_to_uint64.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radix_text_to_uint64: self-checking bench for the radix text parser
// Streams directed and random character strings through the parser under a
// range of radix settings. Every result word is predicted and compared field
// by field, with random idle cycles on the input and stalls on the output.
// ----------------------------------------------------------------------------
module tb_radix_text_to_uint64;
    import rtt_pkg::*;

    localparam int LEN_W   = LENGTH_BITS_DEF;
    localparam int OUT_W   = ((VALUE_W + STATUS_W + LEN_W + 7) / 8) * 8;
    localparam int ST_LSB  = VALUE_W;
    localparam int LEN_LSB = VALUE_W + STATUS_W;

    localparam int unsigned NO_DIGIT      = 99;
    localparam int unsigned MAX_WAIT      = 17;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_CHARS  = 1500;
    localparam int unsigned ZERO_RUN      = 40;
    localparam int unsigned PRINT_LIMIT   = 60;

    localparam logic [VALUE_W-1:0] VALUE_MAX  = '1;
    localparam logic [LEN_W-1:0]   LEN_MAX    = '1;
    localparam logic [RADIX_W-1:0] RADIX_AUTO = '0;
    localparam logic [RADIX_W-1:0] RADIX_ONE  = 6'd1;
    localparam logic [RADIX_W-1:0] RADIX_BIN  = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;

    // Decimal digits of 2**64 with the last one left off.
    localparam string NEAR_MAX_DEC = "1844674407370955161";

    typedef struct {
        item_t word;
        bit    no_gap;
    } char_job_t;

    typedef struct {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    used;
    } parse_result_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [RADIX_W-1:0]  cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [CH_W-1:0]     s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    // Predictor state.
    logic [RADIX_W-1:0]  mode_reg   = '0;
    logic [VALUE_W-1:0]  acc        = '0;
    logic [LEN_W-1:0]    used_chars = '0;
    logic [STATUS_W-1:0] stop_code  = ST_COMPLETE;
    logic [RADIX_W-1:0]  cur_radix  = '0;
    logic                zero_held  = 1'b0;

    char_job_t     char_jobs[$];
    char_job_t     next_job;
    parse_result_t expected_results[$];

    int unsigned words_pending = 0;
    int unsigned chars_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned cfg_writes    = 0;
    int unsigned error_count   = 0;
    int unsigned gap_left      = 0;
    int unsigned stall_left    = 0;
    bit          in_calm       = 1'b0;
    bit          out_calm      = 1'b0;
    logic        char_taken    = 1'b0;
    logic        word_taken    = 1'b0;

    radix_text_to_uint64 u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned digit_value(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] low;
        low = c | CASE_BIT;
        if (c >= CH_ZERO && c <= CH_NINE)
            return c - CH_ZERO;
        if (low >= CH_LOW_A && low <= CH_LOW_Z)
            return low - CH_LOW_A + 10;
        return NO_DIGIT;
    endfunction

    function automatic void add_used(input int unsigned n);
        int unsigned total;
        total      = used_chars + n;
        used_chars = (total > LEN_MAX) ? LEN_MAX : total[LEN_W-1:0];
    endfunction

    // One digit into the accumulator. A multiply overflow keeps the old value,
    // an add overflow keeps the wrapped sum; neither counts as used.
    function automatic void shift_in(input logic [CH_W-1:0] c);
        int unsigned        d;
        logic [VALUE_W-1:0] scaled;
        logic [VALUE_W-1:0] sum;
        if (stop_code != ST_COMPLETE || cur_radix == RADIX_AUTO)
            return;
        d = digit_value(c);
        if (d >= cur_radix)
        begin
            stop_code = ST_STOPPED;
            return;
        end
        if (acc > VALUE_MAX / cur_radix)
        begin
            stop_code = ST_OVERFLOW;
            return;
        end
        scaled = acc * cur_radix;
        sum    = scaled + d;
        acc    = sum;
        if (sum < scaled)
            stop_code = ST_OVERFLOW;
        else
            add_used(1);
    endfunction

    function automatic void predict_word(input item_t w);
        logic [RADIX_W-1:0] pr;
        parse_result_t      res;
        if (w.has_char)
        begin
            if (cur_radix != RADIX_AUTO)
                shift_in(w.ch);
            else if (zero_held)
            begin
                zero_held = 1'b0;
                case (w.ch)
                    CH_LOW_B: pr = RADIX_BIN;
                    CH_LOW_O: pr = RADIX_OCT;
                    CH_LOW_D: pr = RADIX_DEC;
                    CH_LOW_X: pr = RADIX_HEX;
                    default:  pr = RADIX_AUTO;
                endcase
                if (pr != RADIX_AUTO)
                begin
                    cur_radix = pr;
                    add_used(2);
                end
                else
                begin
                    cur_radix = RADIX_DEC;
                    shift_in(CH_ZERO);
                    shift_in(w.ch);
                end
            end
            else if (mode_reg == RADIX_AUTO)
            begin
                // A first zero is held back until the next character shows
                // whether it opens a prefix.
                if (w.ch == CH_ZERO && !w.last)
                    zero_held = 1'b1;
                else
                begin
                    cur_radix = RADIX_DEC;
                    shift_in(w.ch);
                end
            end
            else
            begin
                cur_radix = mode_reg;
                shift_in(w.ch);
            end
        end

        if (!w.last)
            return;

        if (cur_radix == RADIX_AUTO && !zero_held)
        begin
            res.value  = '0;
            res.status = ST_STOPPED;
            res.used   = '0;
        end
        else
        begin
            if (zero_held)
            begin
                zero_held = 1'b0;
                cur_radix = RADIX_DEC;
                shift_in(CH_ZERO);
            end
            res.value  = acc;
            res.status = stop_code;
            res.used   = used_chars;
        end
        expected_results.push_back(res);
        acc        = '0;
        used_chars = '0;
        stop_code  = ST_COMPLETE;
        cur_radix  = RADIX_AUTO;
    endfunction

    function automatic int unsigned draw_wait(input bit out_side);
        if ($urandom_range(0, 39) == 0)
        begin
            if (out_side)
                out_calm = !out_calm;
            else
                in_calm = !in_calm;
        end
        if (out_side ? out_calm : in_calm)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Input side: character words are sampled at the rising edge.
    always @(posedge clk)
    begin
        char_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_word(item_t'({s_tdata, s_tuser, s_tlast}));
            words_pending--;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || char_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (char_jobs.size() > 0)
            begin
                next_job = char_jobs.pop_front();
                s_tdata  <= next_job.word.ch;
                s_tuser  <= next_job.word.has_char;
                s_tlast  <= next_job.word.last;
                s_tvalid <= 1'b1;
                gap_left = next_job.no_gap ? 0 : draw_wait(1'b0);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Output side: result words are checked at the rising edge.
    always @(posedge clk)
    begin
        word_taken <= rst_n && m_tvalid && m_tready;
        if (rst_n && m_tvalid && m_tready)
        begin : check_word
            parse_result_t want;
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch("result word with nothing expected", m_tdata[VALUE_W-1:0], '0);
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[VALUE_W-1:0] !== want.value)
                    report_mismatch("result_value", m_tdata[VALUE_W-1:0], want.value);
                if (m_tdata[ST_LSB +: STATUS_W] !== want.status)
                    report_mismatch("status", VALUE_W'(m_tdata[ST_LSB +: STATUS_W]),
                                    VALUE_W'(want.status));
                if (m_tdata[LEN_LSB +: LEN_W] !== want.used)
                    report_mismatch("used_length", VALUE_W'(m_tdata[LEN_LSB +: LEN_W]),
                                    VALUE_W'(want.used));
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (word_taken)
                stall_left = draw_wait(1'b1);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic push_word(input logic [CH_W-1:0] c, input logic has, input logic fin,
                             input bit burst = 1'b0);
        char_job_t j;
        j.word.ch       = c;
        j.word.has_char = has;
        j.word.last     = fin;
        j.no_gap        = burst;
        char_jobs.push_back(j);
        words_pending++;
        if (has || fin)
            chars_sent++;
    endtask

    task automatic push_text(input string s);
        foreach (s[i])
            push_word(s[i], 1'b1, i == s.len() - 1);
    endtask

    function automatic logic [CH_W-1:0] random_digit(input int unsigned radix);
        int unsigned     v;
        logic [CH_W-1:0] c;
        v = $urandom_range(0, radix - 1);
        if (v < 10)
            return CH_ZERO + CH_W'(v);
        c = CH_LOW_A + CH_W'(v - 10);
        if ($urandom_range(0, 1))
            c = c & ~CASE_BIT;
        return c;
    endfunction

    function automatic logic [CH_W-1:0] invalid_digit(input int unsigned radix);
        logic [CH_W-1:0] c;
        do
            c = CH_W'($urandom_range(0, 255));
        while (digit_value(c) < radix);
        return c;
    endfunction

    // Mostly well-formed numbers with random content, some close to the
    // 64-bit limit, the rest broken strings and raw noise.
    task automatic push_random_string();
        logic [CH_W-1:0] text[$];
        int unsigned     radix;
        int unsigned     kind;
        int unsigned     pick;
        int unsigned     n;
        bit              split_end;
        radix = (mode_reg == RADIX_AUTO) ? RADIX_DEC : mode_reg;
        kind  = $urandom_range(0, 99);
        if (kind < 60)
        begin
            if (mode_reg == RADIX_AUTO && $urandom_range(0, 1))
            begin
                pick = $urandom_range(0, 3);
                text.push_back(CH_ZERO);
                text.push_back(pick == 0 ? CH_LOW_B : pick == 1 ? CH_LOW_O :
                               pick == 2 ? CH_LOW_D : CH_LOW_X);
                radix = pick == 0 ? RADIX_BIN : pick == 1 ? RADIX_OCT :
                        pick == 2 ? RADIX_DEC : RADIX_HEX;
            end
            else if (mode_reg == RADIX_AUTO && $urandom_range(0, 7) == 0)
                text.push_back(CH_ZERO);
            n = ($urandom_range(0, 6) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12);
            repeat (n)
                text.push_back(random_digit(radix));
        end
        else if (kind < 70)
        begin
            if (radix == RADIX_DEC)
            begin
                foreach (NEAR_MAX_DEC[i])
                    text.push_back(NEAR_MAX_DEC[i]);
                repeat ($urandom_range(1, 2))
                    text.push_back(random_digit(RADIX_DEC));
            end
            else
                repeat ($urandom_range(20, 70))
                    text.push_back(random_digit(radix));
        end
        else if (kind < 85)
        begin
            repeat ($urandom_range(0, 10))
                text.push_back(random_digit(radix));
            text.push_back(invalid_digit(radix));
            repeat ($urandom_range(0, 4))
                text.push_back(CH_W'($urandom_range(0, 255)));
        end
        else if (kind < 95)
        begin
            repeat ($urandom_range(0, 8))
                text.push_back(CH_W'($urandom_range(0, 255)));
        end
        else if ($urandom_range(0, 1))
            text.push_back($urandom_range(0, 1) ? CH_ZERO : CH_W'($urandom_range(0, 255)));

        split_end = (text.size() == 0) || ($urandom_range(0, 9) < 3);
        foreach (text[i])
        begin
            if ($urandom_range(0, 19) == 0)
                push_word(CH_W'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_word(text[i], 1'b1, !split_end && i == text.size() - 1);
        end
        if (split_end)
            push_word(CH_W'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Lets the parser drain completely before the radix may change.
    task automatic settle();
        wait (words_pending == 0 && expected_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        mode_reg = (v > RADIX_MAX) ? RADIX_MAX : v;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [RADIX_W-1:0] settings[$];
        int unsigned        target;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Automatic mode straight out of reset: empty string, lone zero,
        // held-back zero at the end, each prefix, a bare prefix and
        // characters that are no digit at all.
        push_word(8'h00, 1'b0, 1'b1);
        push_text("0");
        push_word(CH_ZERO, 1'b1, 1'b0);
        push_word(8'hFF, 1'b0, 1'b1);
        push_text("0xfF");
        push_text("0b101");
        push_text("0o78");
        push_word(CH_ZERO, 1'b1, 1'b0);
        push_word(CH_LOW_D, 1'b1, 1'b0);
        push_word(8'h55, 1'b0, 1'b1);
        push_text("07");
        push_text("Zz");
        push_word(8'hFF, 1'b1, 1'b0);
        push_word(8'h00, 1'b1, 1'b1);
        settle();

        // Radix one accepts only zeros; a run of them sent back to back
        // counts every one.
        write_radix(RADIX_ONE);
        push_text("001");
        repeat (ZERO_RUN)
            push_word(CH_ZERO, 1'b1, 1'b0, 1'b1);
        push_word(CH_ZERO, 1'b0, 1'b1, 1'b1);
        settle();

        settings = '{RADIX_BIN, RADIX_MAX, 6'd37, 6'd63, RADIX_AUTO, RADIX_HEX,
                     RADIX_DEC, RADIX_OCT, RADIX_ONE};
        repeat (3)
            settings.push_back(RADIX_W'($urandom_range(0, 63)));
        settings.push_back(RADIX_AUTO);
        foreach (settings[p])
        begin
            write_radix(settings[p]);
            target = chars_sent + RANDOM_CHARS / settings.size();
            while (chars_sent < target)
                push_random_string();
            settle();
        end

        $display("Parsed %0d strings from %0d character words over %0d radix settings,",
                 results_seen, chars_sent, cfg_writes);
        $display("including prefixes, radix one, clamped radix writes and 64-bit overflow.");
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d result words still outstanding.", expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
